// ===== hdl/rle16_pkg.sv =====
// Package: beat types, queue entry type and constants of the run-length encoder.
`timescale 1ns / 1ps
`default_nettype none
package rle16_pkg;

  localparam int unsigned IdWidth    = 16;
  localparam int unsigned LenWidth   = 16;
  localparam logic [LenWidth-1:0] RunMax = 16'hFFFF;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned PtrWidth   = $clog2(QueueDepth);
  localparam int unsigned CntWidth   = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic [IdWidth-1:0] tile_id;
    logic               last_in;
  } rle16_in_t;

  typedef struct packed {
    logic [LenWidth-1:0] run_length;
    logic [IdWidth-1:0]  run_value;
    logic                last_out;
  } rle16_out_t;

  // Work for the back end: a closed run, a final run, or both.
  typedef struct packed {
    logic                has_close;
    logic [LenWidth-1:0] close_len;
    logic [IdWidth-1:0]  close_val;
    logic                has_final;
    logic [LenWidth-1:0] final_len;
    logic [IdWidth-1:0]  final_val;
  } rle16_entry_t;

endpackage
`default_nettype wire

// ===== hdl/rle16_front.sv =====
// Front end: tracks the open run and classifies each id into queue work.
`timescale 1ns / 1ps
`default_nettype none
module rle16_front (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire rle16_pkg::rle16_in_t   in_data_i,
  input  wire logic                   queue_full_i,
  output logic                        in_stall_o,
  output logic                        push_o,
  output rle16_pkg::rle16_entry_t     push_entry_o
);
  import rle16_pkg::*;

  logic [IdWidth-1:0]  value_q, value_d;
  logic [LenWidth-1:0] count_q, count_d;
  logic                open_q, open_d;
  logic                accept;
  logic                extend;
  logic [IdWidth-1:0]  run_val;
  logic [LenWidth-1:0] run_len;

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;

  // Same id on an open run that still has room: just count it.
  assign extend  = open_q && (in_data_i.tile_id == value_q) && (count_q != RunMax);
  assign run_val = extend ? value_q : in_data_i.tile_id;
  assign run_len = extend ? count_q + 1'b1 : LenWidth'(1);

  always_comb begin
    push_entry_o.has_close = open_q && !extend;
    push_entry_o.close_len = count_q;
    push_entry_o.close_val = value_q;
    push_entry_o.has_final = in_data_i.last_in;
    push_entry_o.final_len = run_len;
    push_entry_o.final_val = run_val;
    push_o = accept && ((open_q && !extend) || in_data_i.last_in);

    value_d = value_q;
    count_d = count_q;
    open_d  = open_q;
    if (accept) begin
      if (in_data_i.last_in) begin
        value_d = '0;
        count_d = '0;
        open_d  = 1'b0;
      end else begin
        value_d = run_val;
        count_d = run_len;
        open_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
      count_q <= '0;
      open_q  <= 1'b0;
    end else begin
      value_q <= value_d;
      count_q <= count_d;
      open_q  <= open_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/rle16_queue.sv =====
// Short queue of run work between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module rle16_queue (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    push_i,
  input  wire rle16_pkg::rle16_entry_t push_entry_i,
  input  wire logic                    pop_i,
  output rle16_pkg::rle16_entry_t      head_o,
  output logic                         not_empty_o,
  output logic                         full_o
);
  import rle16_pkg::*;

  rle16_entry_t        entries_q [QueueDepth];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o      = (cnt_q == CntWidth'(QueueDepth));
  assign not_empty_o = (cnt_q != '0);
  assign head_o      = entries_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && not_empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/rle16_back.sv =====
// Back end: turns queue work into run records, one beat per cycle while the output is not stalled.
`timescale 1ns / 1ps
`default_nettype none
module rle16_back (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire rle16_pkg::rle16_entry_t head_i,
  input  wire logic                    head_valid_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output rle16_pkg::rle16_out_t        out_data_o
);
  import rle16_pkg::*;

  logic       out_valid_q, out_valid_d;
  rle16_out_t out_data_q, out_data_d;
  logic       second_q, second_d;
  logic       load;

  // The output register may refill when empty or when its beat is taken.
  assign load = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    second_d    = second_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = head_valid_i;
      if (head_valid_i) begin
        if (!second_q && head_i.has_close) begin
          out_data_d.run_length = head_i.close_len;
          out_data_d.run_value  = head_i.close_val;
          out_data_d.last_out   = 1'b0;
          // Hold the entry when its final run still has to go out.
          pop_o    = !head_i.has_final;
          second_d = head_i.has_final;
        end else begin
          out_data_d.run_length = head_i.final_len;
          out_data_d.run_value  = head_i.final_val;
          out_data_d.last_out   = 1'b1;
          pop_o    = 1'b1;
          second_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      second_q    <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      second_q    <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

// ===== hdl/rle16_run_encoder_unit.sv =====
// Top level of the streaming 16-bit run-length encoder.
`timescale 1ns / 1ps
`default_nettype none
// Run-length encoder over a stream of 16-bit tile ids, one id per input beat,
// with last_in on the final id. Each output beat is one record (run_length,
// run_value, last_out); a run is closed when a different id arrives or when it
// already holds 65535 ids, and the final id also emits the open run flagged
// last_out. The front end takes one id per cycle while the queue is not full
// and updates the open run in that cycle; its work goes through a four-entry
// queue to the back end, which drives one record per cycle from a registered
// output while out_stall_i is low. An id that closes a run and ends the stream
// yields two records; the queue absorbs that, and in_stall_o rises only while
// the queue is full. A record passes through a queue entry and then the output
// register after the id that caused it is taken.
module rle16_run_encoder_unit (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire rle16_pkg::rle16_in_t  in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output rle16_pkg::rle16_out_t      out_data_o
);
  import rle16_pkg::*;

  logic         push;
  rle16_entry_t push_entry;
  logic         pop;
  rle16_entry_t head;
  logic         head_valid;
  logic         queue_full;

  rle16_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .queue_full_i (queue_full),
    .in_stall_o   (in_stall_o),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  rle16_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .not_empty_o  (head_valid),
    .full_o       (queue_full)
  );

  rle16_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule
`default_nettype wire
